// File: sv/tte_pkg.sv
`default_nettype none

package tte_pkg;

   localparam int TAPS_AVERAGED = 4;

   localparam int SAMPLES_W    = 16;
   localparam int CLOCK_W      = 32;
   localparam int RATE_W       = 18;
   localparam int BPM_W        = 18;
   localparam int INTERVAL_W   = 19;
   localparam int TOTAL_W      = 24;
   localparam int COUNT_OUT_W  = 5;
   localparam int CSR_INDEX_W  = 8;
   localparam int RSP_DATA_W   = 24;

   localparam int POS_W   = $clog2(TAPS_AVERAGED);
   localparam int TAPS_W  = $clog2(TAPS_AVERAGED + 2);
   // count times fifteen, the rest of the 60*256 scale is a shift by ten
   localparam int SCALE_W = $clog2(15 * TAPS_AVERAGED + 1);
   localparam int SHIFT_W = 10;
   localparam int NUM_W   = RATE_W + SCALE_W + SHIFT_W;
   localparam int STEP_W  = $clog2(NUM_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_START_TEMPO = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_BPM     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BPM     = CSR_INDEX_W'(3);

   localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = RATE_W'(48000);
   localparam logic [BPM_W-1:0]  START_TEMPO_RESET = BPM_W'(30720);
   localparam logic [BPM_W-1:0]  MIN_BPM_RESET     = BPM_W'(5120);
   localparam logic [BPM_W-1:0]  MAX_BPM_RESET     = BPM_W'(76800);

endpackage

`default_nettype wire

// File: sv/tap_tempo_estimator_core.sv
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser: op; tdata: samples_elapsed
// rsp       out        rsp_tvalid/rsp_tready  tuser: restarted; tdata: bpm, intervals_averaged
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// an advance word is handled in idle; a tap word steps through gap and update, then the
// restoring divider (one quotient bit a cycle) and clamp unless the sum is zero, then response
// reset is synchronous; config regs go to their reset values, tempo to its start value
// a tap word is accepted while an earlier result waits; the new result then holds
// in its last state until the output register is free
module tap_tempo_estimator_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [tte_pkg::SAMPLES_W-1:0]        req_tdata,  // [15:0] samples_elapsed
   input  wire logic [0:0]                           req_tuser,  // [0] op

   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [tte_pkg::RSP_DATA_W-1:0]            rsp_tdata,  // [17:0] bpm,
                                                                 // [22:18] intervals_averaged
   output logic [0:0]                                rsp_tuser,  // [0] restarted

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tte_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [tte_pkg::RATE_W-1:0]           csr_data
);

   localparam int N = tte_pkg::TAPS_AVERAGED;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_GAP    = 6'b000010,
      S_UPDATE = 6'b000100,
      S_DIV    = 6'b001000,
      S_CLAMP  = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [tte_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [tte_pkg::BPM_W-1:0]      default_ff, default_in;
   logic [tte_pkg::BPM_W-1:0]      min_ff, min_in;
   logic [tte_pkg::BPM_W-1:0]      max_ff, max_in;

   logic [tte_pkg::CLOCK_W-1:0]    clock_ff, clock_in;
   logic [tte_pkg::CLOCK_W-1:0]    last_tap_ff, last_tap_in;
   logic [tte_pkg::CLOCK_W-1:0]    gap_ff, gap_in;
   logic [tte_pkg::TAPS_W-1:0]     taps_ff, taps_in;
   logic [tte_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic [tte_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [tte_pkg::BPM_W-1:0]      tempo_ff, tempo_in;
   logic                           restart_ff, restart_in;

   logic [tte_pkg::INTERVAL_W-1:0] ring_ff [N];
   logic                           ring_we;

   // dividend shifts out the top while quotient bits shift in at the bottom
   logic [tte_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [tte_pkg::TOTAL_W-1:0]    rem_ff, rem_in;
   logic [tte_pkg::STEP_W-1:0]     step_ff, step_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tte_pkg::BPM_W-1:0]      rsp_bpm_ff, rsp_bpm_in;
   logic [tte_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                           rsp_restart_ff, rsp_restart_in;

   // tap update terms
   logic                           upd_restart;
   logic [tte_pkg::TAPS_W-1:0]     upd_taps;
   logic [tte_pkg::TOTAL_W-1:0]    upd_total;
   logic [tte_pkg::INTERVAL_W-1:0] upd_interval;
   logic [tte_pkg::INTERVAL_W-1:0] upd_oldest;
   logic [tte_pkg::TOTAL_W-1:0]    upd_new_total;
   logic [tte_pkg::TAPS_W-1:0]     upd_count;
   logic [tte_pkg::SCALE_W-1:0]    upd_scale;
   logic [tte_pkg::RATE_W+tte_pkg::SCALE_W-1:0] upd_product;

   // divider terms
   logic [tte_pkg::TOTAL_W:0]      div_trial;
   logic [tte_pkg::TOTAL_W+1:0]    div_diff;
   logic                           div_fits;

   // clamp and output terms
   logic [tte_pkg::NUM_W-1:0]      clamp_hi;
   logic [tte_pkg::NUM_W-1:0]      clamp_lo;
   logic [tte_pkg::TAPS_W-1:0]     out_count;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_bpm_ff};
   assign rsp_tuser  = rsp_restart_ff;

   always_comb begin
      upd_restart  = gap_ff > {{(tte_pkg::CLOCK_W - tte_pkg::RATE_W - 1){1'b0}}, rate_ff, 1'b0};
      upd_taps     = upd_restart ? '0 : taps_ff;
      upd_total    = upd_restart ? '0 : total_ff;
      upd_interval = gap_ff[tte_pkg::INTERVAL_W-1:0];
      // an old interval leaves the sum only once the ring has been filled since restart
      upd_oldest   = (upd_taps > tte_pkg::TAPS_W'(N)) ? ring_ff[pos_ff] : '0;
      upd_new_total = upd_total
                    - tte_pkg::TOTAL_W'(upd_oldest)
                    + tte_pkg::TOTAL_W'(upd_interval);
      upd_count    = (upd_taps < tte_pkg::TAPS_W'(N)) ? upd_taps : tte_pkg::TAPS_W'(N);
      upd_scale    = tte_pkg::SCALE_W'(upd_count) * tte_pkg::SCALE_W'(15);
      upd_product  = (tte_pkg::RATE_W + tte_pkg::SCALE_W)'(rate_ff)
                   * (tte_pkg::RATE_W + tte_pkg::SCALE_W)'(upd_scale);
   end

   always_comb begin
      div_trial = {rem_ff, num_ff[tte_pkg::NUM_W-1]};
      div_diff  = {1'b0, div_trial} - {2'b00, total_ff};
      div_fits  = ~div_diff[tte_pkg::TOTAL_W+1];
   end

   always_comb begin
      clamp_hi  = (num_ff > tte_pkg::NUM_W'(max_ff)) ? tte_pkg::NUM_W'(max_ff) : num_ff;
      clamp_lo  = (clamp_hi < tte_pkg::NUM_W'(min_ff)) ? tte_pkg::NUM_W'(min_ff) : clamp_hi;
      out_count = taps_ff - tte_pkg::TAPS_W'(1);
      if (out_count > tte_pkg::TAPS_W'(N)) begin
         out_count = tte_pkg::TAPS_W'(N);
      end
   end

   always_comb begin
      state_in       = state_ff;
      rate_in        = rate_ff;
      default_in     = default_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      clock_in       = clock_ff;
      last_tap_in    = last_tap_ff;
      gap_in         = gap_ff;
      taps_in        = taps_ff;
      total_in       = total_ff;
      pos_in         = pos_ff;
      tempo_in       = tempo_ff;
      restart_in     = restart_ff;
      ring_we        = 1'b0;
      num_in         = num_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_bpm_in     = rsp_bpm_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_restart_in = rsp_restart_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  state_in = S_GAP;
               end else begin
                  clock_in = clock_ff + tte_pkg::CLOCK_W'(req_tdata);
               end
            end
         end
         S_GAP: begin
            gap_in   = clock_ff - last_tap_ff;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            restart_in  = upd_restart;
            last_tap_in = clock_ff;
            taps_in     = (upd_taps < tte_pkg::TAPS_W'(N + 1))
                        ? upd_taps + tte_pkg::TAPS_W'(1) : upd_taps;
            total_in    = upd_total;
            rem_in      = '0;
            step_in     = '0;
            num_in      = {upd_product, {tte_pkg::SHIFT_W{1'b0}}};
            state_in    = S_RESP;
            if (upd_taps != '0) begin
               ring_we  = 1'b1;
               total_in = upd_new_total;
               pos_in   = (pos_ff == tte_pkg::POS_W'(N - 1))
                        ? '0 : pos_ff + tte_pkg::POS_W'(1);
               // a zero sum keeps the old tempo
               if (upd_new_total != '0) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in  = div_fits ? div_diff[tte_pkg::TOTAL_W-1:0]
                               : div_trial[tte_pkg::TOTAL_W-1:0];
            num_in  = {num_ff[tte_pkg::NUM_W-2:0], div_fits};
            step_in = step_ff + tte_pkg::STEP_W'(1);
            if (step_ff == tte_pkg::STEP_W'(tte_pkg::NUM_W - 1)) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            tempo_in = clamp_lo[tte_pkg::BPM_W-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_bpm_in     = tempo_ff;
               rsp_count_in   = tte_pkg::COUNT_OUT_W'(out_count);
               rsp_restart_in = restart_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            tte_pkg::CSR_SAMPLE_RATE: rate_in = csr_data;
            tte_pkg::CSR_START_TEMPO: begin
               default_in = csr_data;
               tempo_in   = csr_data;
            end
            tte_pkg::CSR_MIN_BPM:     min_in = csr_data;
            tte_pkg::CSR_MAX_BPM:     max_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= tte_pkg::SAMPLE_RATE_RESET;
         default_ff   <= tte_pkg::START_TEMPO_RESET;
         min_ff       <= tte_pkg::MIN_BPM_RESET;
         max_ff       <= tte_pkg::MAX_BPM_RESET;
         clock_ff     <= '0;
         last_tap_ff  <= '0;
         taps_ff      <= '0;
         total_ff     <= '0;
         pos_ff       <= '0;
         tempo_ff     <= tte_pkg::START_TEMPO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         default_ff   <= default_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         clock_ff     <= clock_in;
         last_tap_ff  <= last_tap_in;
         taps_ff      <= taps_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         tempo_ff     <= tempo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gap_ff         <= gap_in;
      restart_ff     <= restart_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      rsp_bpm_ff     <= rsp_bpm_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_restart_ff <= rsp_restart_in;
      if (ring_we) begin
         ring_ff[pos_ff] <= upd_interval;
      end
   end

endmodule

`default_nettype wire
